// ----- hw/rtl/drc_pkg.sv -----
package drc_pkg;

  localparam int COORD_BITS  = 12;
  localparam int CAPACITY    = 24;
  localparam int IN_BITS     = 16;
  localparam int GAP_BITS    = 4;
  localparam int REV_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RST  = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RST = COORD_BITS'(480);
  localparam logic [GAP_BITS-1:0]   JOIN_GAP_RST      = GAP_BITS'(2);

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_JOIN_GAP      = 2'd2;

  typedef enum logic [1:0] {
    ACT_RECT  = 2'd0,
    ACT_ALL   = 2'd1,
    ACT_DRAIN = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } region_t;

  typedef struct packed {
    action_t             action;
    logic [IN_BITS-1:0]  rect_x;
    logic [IN_BITS-1:0]  rect_y;
    logic [IN_BITS-1:0]  rect_width;
    logic [IN_BITS-1:0]  rect_height;
  } cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COORD_BITS-1:0] out_width;
    logic [COORD_BITS-1:0] out_height;
    logic                  entry_valid;
    logic                  last;
    logic [REV_BITS-1:0]   revision;
  } result_t;

endpackage

// ----- hw/rtl/drc_ram.sv -----
module drc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 24
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/dirty_rect_coalescer.sv -----
// invalidate rectangle: entries are scanned through the shared 12x12 multiplier and table
// read port, each merge restarts the scan, then the rectangle is appended. invalidate whole
// screen: empties the table and appends the clamped screen; clear table: accepted with busy
// staying low. drain: words go out through the table read port, last word ends busy; an
// empty table gives one word in the cycle after start. results cannot be stalled. reset
// clears count and revision and loads screen and gap defaults; table contents stay undefined
module dirty_rect_coalescer #(
  parameter int CAPACITY = drc_pkg::CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  drc_pkg::cmd_t                       cmd,
  output logic                                result_valid,
  output drc_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [drc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [drc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CB   = drc_pkg::COORD_BITS;
  localparam int IB   = drc_pkg::IN_BITS;
  localparam int AB   = 2 * CB;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RW   = $bits(drc_pkg::region_t);

  typedef enum logic [3:0] {
    S_IDLE, S_CLAMP, S_AREA_R, S_SCAN_RD, S_BBOX, S_UAREA, S_TEST,
    S_MOVE_RD, S_MOVE_WR, S_APPEND, S_DRAIN_RD, S_DRAIN_OUT
  } state_t;

  state_t state;

  logic [CB-1:0]                 screen_width;
  logic [CB-1:0]                 screen_height;
  logic [drc_pkg::GAP_BITS-1:0]  join_gap;
  logic [drc_pkg::REV_BITS-1:0]  revision;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 idx;

  logic [IB-1:0] raw_x, raw_y, raw_w, raw_h;
  drc_pkg::region_t rect;
  drc_pkg::region_t ubox;
  logic             near;
  logic [AB-1:0]    rect_area;
  logic [AB-1:0]    entry_area;
  logic [AB-1:0]    ubox_area;
  logic [AB:0]      area_sum;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [RW-1:0]    ram_wdata;
  logic [RW-1:0]    ram_rdata;
  drc_pkg::region_t entry;
  drc_pkg::region_t full_screen;

  assign entry       = drc_pkg::region_t'(ram_rdata);
  assign full_screen = '{x: '0, y: '0, w: screen_width, h: screen_height};
  assign busy        = (state != S_IDLE);
  assign cfg_ready   = !busy;

  drc_ram #(
    .WIDTH(RW),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // clamp
  logic [IB:0]   clip_x1, clip_y1, sw_ext, sh_ext, clip_x1c, clip_y1c;
  logic          clip_off;
  logic [CB-1:0] clip_w, clip_h;
  logic          clip_empty;

  always_comb begin
    sw_ext     = (IB + 1)'(screen_width);
    sh_ext     = (IB + 1)'(screen_height);
    clip_x1    = {1'b0, raw_x} + {1'b0, raw_w};
    clip_y1    = {1'b0, raw_y} + {1'b0, raw_h};
    clip_x1c   = (clip_x1 > sw_ext) ? sw_ext : clip_x1;
    clip_y1c   = (clip_y1 > sh_ext) ? sh_ext : clip_y1;
    clip_off   = ({1'b0, raw_x} >= sw_ext) || ({1'b0, raw_y} >= sh_ext);
    clip_w     = CB'(clip_x1c - {1'b0, raw_x});
    clip_h     = CB'(clip_y1c - {1'b0, raw_y});
    clip_empty = clip_off || (clip_w == '0) || (clip_h == '0);
  end

  // bounding box and proximity of table entry vs rectangle
  logic [CB+1:0] ex1, ey1, rx1, ry1, gap_ext, ux1, uy1;
  logic [CB-1:0] ux0, uy0;
  logic          near_now;
  drc_pkg::region_t ubox_now;

  always_comb begin
    gap_ext  = (CB + 2)'(join_gap);
    ex1      = (CB + 2)'(entry.x) + (CB + 2)'(entry.w);
    ey1      = (CB + 2)'(entry.y) + (CB + 2)'(entry.h);
    rx1      = (CB + 2)'(rect.x) + (CB + 2)'(rect.w);
    ry1      = (CB + 2)'(rect.y) + (CB + 2)'(rect.h);
    near_now = ((CB + 2)'(entry.x) <= rx1 + gap_ext) && ((CB + 2)'(rect.x) <= ex1 + gap_ext) &&
               ((CB + 2)'(entry.y) <= ry1 + gap_ext) && ((CB + 2)'(rect.y) <= ey1 + gap_ext);
    ux0      = (entry.x < rect.x) ? entry.x : rect.x;
    uy0      = (entry.y < rect.y) ? entry.y : rect.y;
    ux1      = (ex1 > rx1) ? ex1 : rx1;
    uy1      = (ey1 > ry1) ? ey1 : ry1;
    ubox_now = '{x: ux0, y: uy0, w: CB'(ux1 - (CB + 2)'(ux0)), h: CB'(uy1 - (CB + 2)'(uy0))};
  end

  // shared multiplier
  logic [CB-1:0] mul_a, mul_b;
  logic [AB-1:0] mul_p;

  always_comb begin
    case (state)
      S_AREA_R: begin
        mul_a = rect.w;
        mul_b = rect.h;
      end
      S_BBOX: begin
        mul_a = entry.w;
        mul_b = entry.h;
      end
      default: begin
        mul_a = ubox.w;
        mul_b = ubox.h;
      end
    endcase
    mul_p = AB'(mul_a * mul_b);
  end

  // merge test: union area against floor(5/4 of the summed areas)
  logic [AB+3:0] lim5;
  logic [AB+1:0] lim;
  logic          merge;

  always_comb begin
    lim5  = {1'b0, area_sum, 2'b00} + {3'b000, area_sum};
    lim   = lim5[AB+3:2];
    merge = near && ({2'b00, ubox_area} <= lim);
  end

  logic table_full;
  assign table_full = (count == CW'(CAPACITY));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[AW-1:0];
    case (state)
      S_MOVE_RD: begin
        ram_raddr = count[AW-1:0];
      end
      S_MOVE_WR: begin
        ram_we = 1'b1;
      end
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = table_full ? '0 : count[AW-1:0];
        ram_wdata = table_full ? RW'(full_screen) : RW'(rect);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      screen_width  <= drc_pkg::SCREEN_WIDTH_RST;
      screen_height <= drc_pkg::SCREEN_HEIGHT_RST;
      join_gap      <= drc_pkg::JOIN_GAP_RST;
      revision      <= '0;
      count         <= '0;
      idx           <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= (state == S_DRAIN_OUT) ||
                      ((state == S_IDLE) && start && (cmd.action == drc_pkg::ACT_DRAIN) &&
                       (count == '0));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          drc_pkg::CFG_SCREEN_WIDTH:  screen_width  <= CB'(cfg_data);
          drc_pkg::CFG_SCREEN_HEIGHT: screen_height <= CB'(cfg_data);
          drc_pkg::CFG_JOIN_GAP:      join_gap      <= drc_pkg::GAP_BITS'(cfg_data);
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            idx <= '0;
            case (cmd.action)
              drc_pkg::ACT_RECT: begin
                raw_x <= cmd.rect_x;
                raw_y <= cmd.rect_y;
                raw_w <= cmd.rect_width;
                raw_h <= cmd.rect_height;
                state <= S_CLAMP;
              end
              drc_pkg::ACT_ALL: begin
                count <= '0;
                raw_x <= '0;
                raw_y <= '0;
                raw_w <= IB'(screen_width);
                raw_h <= IB'(screen_height);
                state <= S_CLAMP;
              end
              drc_pkg::ACT_DRAIN: begin
                if (count == '0) begin
                  result <= '{out_x: '0, out_y: '0, out_width: '0, out_height: '0,
                              entry_valid: 1'b0, last: 1'b1, revision: revision};
                end else begin
                  state <= S_DRAIN_RD;
                end
              end
              drc_pkg::ACT_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLAMP: begin
          rect <= '{x: CB'(raw_x), y: CB'(raw_y), w: clip_w, h: clip_h};
          if (clip_empty) begin
            state <= S_IDLE;
          end else begin
            revision <= revision + 1'b1;
            state    <= S_AREA_R;
          end
        end
        S_AREA_R: begin
          rect_area <= mul_p;
          idx       <= '0;
          state     <= (count == '0) ? S_APPEND : S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state <= S_BBOX;
        end
        S_BBOX: begin
          entry_area <= mul_p;
          ubox       <= ubox_now;
          near       <= near_now;
          state      <= S_UAREA;
        end
        S_UAREA: begin
          ubox_area <= mul_p;
          area_sum  <= {1'b0, entry_area} + {1'b0, rect_area};
          state     <= S_TEST;
        end
        S_TEST: begin
          if (merge) begin
            rect      <= ubox;
            rect_area <= ubox_area;
            count     <= count - 1'b1;
            state     <= S_MOVE_RD;
          end else if (idx + 1'b1 < count) begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_RD;
          end else begin
            state <= S_APPEND;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          idx   <= '0;
          state <= (count == '0) ? S_APPEND : S_SCAN_RD;
        end
        S_APPEND: begin
          count <= table_full ? CW'(1) : count + 1'b1;
          state <= S_IDLE;
        end
        S_DRAIN_RD: begin
          state <= S_DRAIN_OUT;
        end
        S_DRAIN_OUT: begin
          result       <= '{out_x: entry.x, out_y: entry.y, out_width: entry.w,
                            out_height: entry.h, entry_valid: 1'b1,
                            last: (idx + 1'b1 == count), revision: revision};
          idx          <= idx + 1'b1;
          if (idx + 1'b1 == count) begin
            count <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_DRAIN_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy && count == '0)
    else $error("final drain word while busy or table not empty");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.entry_valid |-> result.last)
    else $error("empty-table word without last");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without start");

endmodule

// ----- tb/drc_checker.sv -----
`timescale 1ns / 1ps
module drc_checker
  import drc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  cmd_t                     cmd,
  input  logic                     result_valid,
  input  result_t                  result,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       fail_count,
  output int                       words_owed
);

  region_t               dirty_tbl [CAPACITY];
  int unsigned           dirty_cnt;
  logic [REV_BITS-1:0]   rev_cnt;
  logic [COORD_BITS-1:0] scr_w;
  logic [COORD_BITS-1:0] scr_h;
  logic [GAP_BITS-1:0]   gap;
  result_t               word_q [$];
  int                    errors = 0;

  task automatic flag(string msg);
    $display("[%0t] drc mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic bit touching(region_t a, region_t b);
    int unsigned ax1, ay1, bx1, by1;
    ax1 = a.x + a.w + gap;
    ay1 = a.y + a.h + gap;
    bx1 = b.x + b.w + gap;
    by1 = b.y + b.h + gap;
    return a.x <= bx1 && b.x <= ax1 && a.y <= by1 && b.y <= ay1;
  endfunction

  function automatic region_t span(region_t a, region_t b);
    region_t     r;
    int unsigned ae, be, af, bf, x1, y1;
    ae = a.x + a.w;
    be = b.x + b.w;
    af = a.y + a.h;
    bf = b.y + b.h;
    x1 = (ae > be) ? ae : be;
    y1 = (af > bf) ? af : bf;
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    r.w = COORD_BITS'(x1 - r.x);
    r.h = COORD_BITS'(y1 - r.y);
    return r;
  endfunction

  task automatic mark_dirty(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
    region_t         r, e, u;
    int unsigned     x1, y1, i;
    longint unsigned ua, lim;
    if (x >= scr_w || y >= scr_h) return;
    x1 = x + w;
    y1 = y + h;
    if (x1 > scr_w) x1 = scr_w;
    if (y1 > scr_h) y1 = scr_h;
    if (x1 == x || y1 == y) return;
    r.x = COORD_BITS'(x);
    r.y = COORD_BITS'(y);
    r.w = COORD_BITS'(x1 - x);
    r.h = COORD_BITS'(y1 - y);
    rev_cnt++;
    i = 0;
    while (i < dirty_cnt && i < CAPACITY) begin
      e = dirty_tbl[i];
      u = span(e, r);
      ua = 64'(u.w) * 64'(u.h);
      lim = (64'(e.w) * 64'(e.h) + 64'(r.w) * 64'(r.h)) * 64'd5 / 64'd4;
      if (touching(e, r) && ua <= lim) begin
        r = u;
        dirty_cnt--;
        dirty_tbl[i] = dirty_tbl[dirty_cnt];
        i = 0;
      end else begin
        i++;
      end
    end
    if (dirty_cnt < CAPACITY) begin
      dirty_tbl[dirty_cnt] = r;
      dirty_cnt++;
    end else begin
      // table overflow collapses to the whole screen
      dirty_cnt = 1;
      dirty_tbl[0].x = '0;
      dirty_tbl[0].y = '0;
      dirty_tbl[0].w = scr_w;
      dirty_tbl[0].h = scr_h;
    end
  endtask

  task automatic take_cmd(cmd_t c);
    result_t     w;
    int unsigned k;
    case (c.action)
      ACT_RECT: begin
        mark_dirty(c.rect_x, c.rect_y, c.rect_width, c.rect_height);
      end
      ACT_ALL: begin
        dirty_cnt = 0;
        mark_dirty(0, 0, scr_w, scr_h);
      end
      ACT_DRAIN: begin
        w = '0;
        w.revision = rev_cnt;
        if (dirty_cnt == 0) begin
          w.last = 1'b1;
          word_q.push_back(w);
        end else begin
          for (k = 0; k < dirty_cnt; k++) begin
            w.out_x = dirty_tbl[k].x;
            w.out_y = dirty_tbl[k].y;
            w.out_width = dirty_tbl[k].w;
            w.out_height = dirty_tbl[k].h;
            w.entry_valid = 1'b1;
            w.last = (k + 1 == dirty_cnt);
            word_q.push_back(w);
          end
        end
        dirty_cnt = 0;
      end
      ACT_CLEAR: begin
        dirty_cnt = 0;
      end
      default: begin
        flag("unknown action on accepted command");
      end
    endcase
  endtask

  task automatic check_word(result_t got);
    result_t want;
    if (word_q.size() == 0) begin
      flag("result word with nothing expected");
      return;
    end
    want = word_q.pop_front();
    if (got.out_x !== want.out_x)
      flag($sformatf("out_x %0d, expected %0d", got.out_x, want.out_x));
    if (got.out_y !== want.out_y)
      flag($sformatf("out_y %0d, expected %0d", got.out_y, want.out_y));
    if (got.out_width !== want.out_width)
      flag($sformatf("out_width %0d, expected %0d", got.out_width, want.out_width));
    if (got.out_height !== want.out_height)
      flag($sformatf("out_height %0d, expected %0d", got.out_height, want.out_height));
    if (got.entry_valid !== want.entry_valid)
      flag($sformatf("entry_valid %0b, expected %0b", got.entry_valid, want.entry_valid));
    if (got.last !== want.last)
      flag($sformatf("last %0b, expected %0b", got.last, want.last));
    if (got.revision !== want.revision)
      flag($sformatf("revision %0d, expected %0d", got.revision, want.revision));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dirty_cnt = 0;
      rev_cnt = '0;
      scr_w = SCREEN_WIDTH_RST;
      scr_h = SCREEN_HEIGHT_RST;
      gap = JOIN_GAP_RST;
      word_q.delete();
    end else begin
      if (result_valid) check_word(result);
      if (start && !busy) take_cmd(cmd);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:  scr_w = cfg_data[COORD_BITS-1:0];
          CFG_SCREEN_HEIGHT: scr_h = cfg_data[COORD_BITS-1:0];
          CFG_JOIN_GAP:      gap = cfg_data[GAP_BITS-1:0];
          default: ;
        endcase
      end
    end
    words_owed <= word_q.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import drc_pkg::*;

  localparam int LIMIT = 2_000_000;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  cmd_t                     cmd = '0;
  logic                     result_valid;
  result_t                  result;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  int                       fail_count;
  int                       words_owed;
  int                       cycle_cnt = 0;
  int unsigned              cur_w = 320;
  int unsigned              cur_h = 480;
  int unsigned              cur_gap = 2;
  bit                       calm = 1'b0;

  dirty_rect_coalescer i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  drc_checker i_chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .words_owed   (words_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int idle_cycles();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue(action_t a, int unsigned x = 0, int unsigned y = 0,
                       int unsigned w = 0, int unsigned h = 0);
    cmd_t c;
    int   g;
    c.action = a;
    c.rect_x = IN_BITS'(x);
    c.rect_y = IN_BITS'(y);
    c.rect_width = IN_BITS'(w);
    c.rect_height = IN_BITS'(h);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    g = idle_cycles();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (words_owed != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(data);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned g);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_JOIN_GAP, g);
    write_reg(CFG_UNUSED, $urandom_range(0, 4095));
    cfg_valid <= 1'b0;
    cur_w = w % 4096;
    cur_h = h % 4096;
    cur_gap = g % 16;
  endtask

  // overlapping rectangles around one spot, some cut at the screen edge
  task automatic burst_cluster(int n);
    int unsigned cx, cy;
    cx = $urandom_range(0, cur_w);
    cy = $urandom_range(0, cur_h);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        issue(ACT_RECT, cx + $urandom_range(0, 16), cy + $urandom_range(0, 16),
              $urandom_range(0, 1) ? 0 : 16'hFFFF, $urandom_range(1, 60));
      else
        issue(ACT_RECT, cx + $urandom_range(0, 24), cy + $urandom_range(0, 24),
              $urandom_range(1, 40), $urandom_range(1, 40));
    end
  endtask

  // tiny rectangles spaced beyond the join gap, enough to overflow the table
  task automatic burst_grid(int n);
    int unsigned step, cols;
    step = cur_gap + 3;
    cols = cur_w / step;
    if (cols == 0) cols = 1;
    for (int k = 0; k < n; k++)
      issue(ACT_RECT, (k % cols) * step, (k / cols) * step,
            $urandom_range(1, 2), $urandom_range(1, 2));
  endtask

  task automatic burst_noise(int n);
    repeat (n)
      issue(action_t'($urandom_range(0, 3)), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  initial begin
    int budget, n, pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    issue(ACT_DRAIN);
    issue(ACT_RECT, 10, 10, 20, 20);
    issue(ACT_RECT, 14, 12, 20, 20);
    issue(ACT_RECT, 200, 300, 50, 50);
    issue(ACT_RECT, 0, 0, 0, 5);
    issue(ACT_RECT, 5, 5, 5, 0);
    issue(ACT_RECT, 320, 0, 10, 10);
    issue(ACT_RECT, 0, 480, 10, 10);
    issue(ACT_RECT, 300, 470, 16'hFFFF, 16'hFFFF);
    issue(ACT_RECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(ACT_DRAIN);
    issue(ACT_ALL);
    issue(ACT_RECT, 5, 5, 10, 10);
    issue(ACT_DRAIN);
    issue(ACT_RECT, 0, 0, 1, 1);
    issue(ACT_CLEAR);
    issue(ACT_DRAIN);
    issue(ACT_CLEAR);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: configure(4095, 4095, 15);
        1: configure(1, 1, 0);
        2: configure(0, $urandom_range(1, 4095), $urandom_range(0, 15));
        3: configure($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095));
        4: configure(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, JOIN_GAP_RST);
        default: configure($urandom_range(16, 640), $urandom_range(16, 640),
                           $urandom_range(0, 15));
      endcase
      calm = ($urandom_range(0, 2) == 0);
      issue(ACT_ALL);
      if (ph == 0 || ph == 4) burst_grid(24 + $urandom_range(1, 3));
      budget = 0;
      while (budget < 8) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          n = $urandom_range(2, 8);
          burst_cluster(n);
        end else if (pick < 7) begin
          n = $urandom_range(1, 4);
          burst_noise(n);
        end else begin
          n = 1;
          issue(action_t'($urandom_range(int'(ACT_ALL), int'(ACT_CLEAR))));
        end
        budget += n;
        if ($urandom_range(0, 1)) issue(ACT_DRAIN);
      end
      issue(ACT_DRAIN);
    end
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/drc_pkg.sv
hw/rtl/drc_ram.sv
hw/rtl/dirty_rect_coalescer.sv
tb/drc_checker.sv
tb/tb_top.sv
